// ----- rtl/jts_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package jts_pkg;

    // longest lexeme in bytes and the width of its length counter
    localparam int MAX_LEXEME = 1024;
    localparam int LEN_W      = $clog2(MAX_LEXEME + 1);

    // output queue geometry
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int LEVEL_W    = $clog2(FIFO_DEPTH + 1);

    // character codes
    localparam logic [7:0] CH_NEWLINE     = 8'h0a;
    localparam logic [7:0] CH_SPACE       = 8'h20;
    localparam logic [7:0] CH_QUOTE       = 8'h22;
    localparam logic [7:0] CH_COMMA       = 8'h2c;
    localparam logic [7:0] CH_DOT         = 8'h2e;
    localparam logic [7:0] CH_COLON       = 8'h3a;
    localparam logic [7:0] CH_BRACKET_OPN = 8'h5b;
    localparam logic [7:0] CH_BRACKET_CLS = 8'h5d;
    localparam logic [7:0] CH_BRACE_OPN   = 8'h7b;
    localparam logic [7:0] CH_BRACE_CLS   = 8'h7d;

    // word indexes into the keyword table
    localparam logic [1:0] WORD_TRUE  = 2'd0;
    localparam logic [1:0] WORD_FALSE = 2'd1;
    localparam logic [1:0] WORD_NULL  = 2'd2;

    typedef enum logic [3:0] {
        KIND_BRACE_OPEN    = 4'd0,
        KIND_BRACE_CLOSE   = 4'd1,
        KIND_BRACKET_OPEN  = 4'd2,
        KIND_BRACKET_CLOSE = 4'd3,
        KIND_COLON         = 4'd4,
        KIND_COMMA         = 4'd5,
        KIND_KEY           = 4'd6,
        KIND_STRING        = 4'd7,
        KIND_NUMBER        = 4'd8,
        KIND_BOOL          = 4'd9,
        KIND_EOF           = 4'd10
    } token_kind_t;

    typedef enum logic [2:0] {
        ERR_NONE         = 3'd0,
        ERR_UNEXPECTED   = 3'd1,
        ERR_UNQUOTED     = 3'd2,
        ERR_UNTERMINATED = 3'd3,
        ERR_TOO_LONG     = 3'd4
    } error_code_t;

    // one result item as it sits in the output queue
    typedef struct packed {
        logic        token_done;
        token_kind_t token_kind;
        logic [7:0]  lexeme_byte;
        error_code_t error_code;
        logic [15:0] line_number;
        logic        last_of_run;
    } result_t;

    typedef struct packed {
        logic       halted;
        logic [1:0] push_count;
    } scan_status_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
    } fifo_status_t;

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h7a)) || ((b >= 8'h41) && (b <= 8'h5a));
    endfunction

    // length of each keyword
    function automatic logic [2:0] word_len(input logic [1:0] idx);
        logic [2:0] len;
        unique case (idx)
            WORD_TRUE:  len = 3'd4;
            WORD_FALSE: len = 3'd5;
            WORD_NULL:  len = 3'd4;
            default:    len = 3'd0;
        endcase
        return len;
    endfunction

    // character of a keyword at a position, zero past its end
    function automatic logic [7:0] word_char(input logic [1:0] idx, input logic [2:0] pos);
        logic [39:0] text;
        logic [7:0]  ch;
        unique case (idx)
            WORD_TRUE:  text = {8'h00, 8'h65, 8'h75, 8'h72, 8'h74};
            WORD_FALSE: text = {8'h65, 8'h73, 8'h6c, 8'h61, 8'h66};
            WORD_NULL:  text = {8'h00, 8'h6c, 8'h6c, 8'h75, 8'h6e};
            default:    text = '0;
        endcase
        unique case (pos)
            3'd0:    ch = text[7:0];
            3'd1:    ch = text[15:8];
            3'd2:    ch = text[23:16];
            3'd3:    ch = text[31:24];
            3'd4:    ch = text[39:32];
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/jts_scan.sv -----
`timescale 1ns / 1ps
`default_nettype none

module jts_scan
    import jts_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         step_en,
    input  wire logic [7:0]   data_byte,
    input  wire logic         end_of_input,
    input  wire logic         cfg_we,
    input  wire logic [15:0]  cfg_data,
    output result_t           push_first,
    output result_t           push_second,
    output scan_status_t      status
);

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_STR   = 3'd1,
        MODE_AFTER = 3'd2,
        MODE_INT   = 3'd3,
        MODE_FRAC  = 3'd4,
        MODE_WORD  = 3'd5
    } mode_t;

    mode_t            mode_reg, mode_next;
    logic [2:0]       match_reg, match_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [15:0]      line_reg, line_next;
    logic             halted_reg, halted_next;

    result_t          res [2];
    logic [1:0]       res_count;
    logic             rescan;
    logic             add_byte;
    logic             word_ok;

    function automatic result_t mk(input logic done, input token_kind_t kind,
                                   input logic [7:0] byte_v, input error_code_t err,
                                   input logic [15:0] line);
        result_t r;
        r.token_done  = done;
        r.token_kind  = kind;
        r.lexeme_byte = byte_v;
        r.error_code  = err;
        r.line_number = line;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    // line count after this byte's newline
    always_comb
    begin
        line_next = line_reg;
        if (!halted_reg && !end_of_input && data_byte == CH_NEWLINE && line_reg != 16'hffff)
        begin
            line_next = line_reg + 16'd1;
        end
    end

    // a word lexeme closes cleanly only on a full keyword
    assign word_ok = (match_reg[WORD_TRUE]  && len_reg == LEN_W'(word_len(WORD_TRUE)))  ||
                     (match_reg[WORD_FALSE] && len_reg == LEN_W'(word_len(WORD_FALSE))) ||
                     (match_reg[WORD_NULL]  && len_reg == LEN_W'(word_len(WORD_NULL)));

    // one step of scanning: close token, rescan the byte, append lexeme byte, or close at end of input
    always_comb
    begin
        mode_next   = mode_reg;
        match_next  = match_reg;
        len_next    = len_reg;
        halted_next = halted_reg;
        res[0]      = mk(1'b0, KIND_BRACE_OPEN, 8'h00, ERR_NONE, line_next);
        res[1]      = res[0];
        res_count   = 2'd0;
        rescan      = 1'b0;
        add_byte    = 1'b0;

        if (!halted_reg)
        begin
            if (end_of_input)
            begin
                unique case (mode_reg)
                    MODE_STR:
                    begin
                        res[res_count[0]] = mk(1'b0, KIND_BRACE_OPEN, 8'h00,
                                               ERR_UNTERMINATED, line_next);
                        res_count   = res_count + 2'd1;
                        halted_next = 1'b1;
                    end
                    MODE_AFTER:
                    begin
                        res[res_count[0]] = mk(1'b1, KIND_STRING, 8'h00, ERR_NONE, line_next);
                        res_count = res_count + 2'd1;
                    end
                    MODE_INT, MODE_FRAC:
                    begin
                        res[res_count[0]] = mk(1'b1, KIND_NUMBER, 8'h00, ERR_NONE, line_next);
                        res_count = res_count + 2'd1;
                    end
                    MODE_WORD:
                    begin
                        if (word_ok)
                        begin
                            res[res_count[0]] = mk(1'b1, KIND_BOOL, 8'h00, ERR_NONE, line_next);
                        end
                        else
                        begin
                            res[res_count[0]] = mk(1'b0, KIND_BRACE_OPEN, 8'h00,
                                                   ERR_UNQUOTED, line_next);
                            halted_next = 1'b1;
                        end
                        res_count = res_count + 2'd1;
                    end
                    default: ;
                endcase
                if (!halted_next)
                begin
                    res[res_count[0]] = mk(1'b1, KIND_EOF, 8'h00, ERR_NONE, line_next);
                    res_count  = res_count + 2'd1;
                    mode_next  = MODE_IDLE;
                    len_next   = '0;
                    match_next = 3'b111;
                end
            end
            else
            begin
                // continue or close the open lexeme
                unique case (mode_reg)
                    MODE_STR:
                    begin
                        if (data_byte == CH_QUOTE)
                        begin
                            mode_next = MODE_AFTER;
                            len_next  = '0;
                        end
                        else
                        begin
                            add_byte = 1'b1;
                        end
                    end
                    MODE_AFTER:
                    begin
                        if (!is_space(data_byte))
                        begin
                            res[res_count[0]] = mk(1'b1,
                                                   (data_byte == CH_COLON) ? KIND_KEY : KIND_STRING,
                                                   8'h00, ERR_NONE, line_next);
                            res_count = res_count + 2'd1;
                            rescan    = 1'b1;
                        end
                    end
                    MODE_INT:
                    begin
                        if (is_digit(data_byte))
                        begin
                            add_byte = 1'b1;
                        end
                        else if (data_byte == CH_DOT)
                        begin
                            add_byte  = 1'b1;
                            mode_next = MODE_FRAC;
                        end
                        else
                        begin
                            res[res_count[0]] = mk(1'b1, KIND_NUMBER, 8'h00, ERR_NONE, line_next);
                            res_count = res_count + 2'd1;
                            rescan    = 1'b1;
                        end
                    end
                    MODE_FRAC:
                    begin
                        if (is_digit(data_byte))
                        begin
                            add_byte = 1'b1;
                        end
                        else
                        begin
                            res[res_count[0]] = mk(1'b1, KIND_NUMBER, 8'h00, ERR_NONE, line_next);
                            res_count = res_count + 2'd1;
                            rescan    = 1'b1;
                        end
                    end
                    MODE_WORD:
                    begin
                        if (is_alpha(data_byte) || is_digit(data_byte))
                        begin
                            add_byte = 1'b1;
                        end
                        else if (!word_ok)
                        begin
                            res[res_count[0]] = mk(1'b0, KIND_BRACE_OPEN, 8'h00,
                                                   ERR_UNQUOTED, line_next);
                            res_count   = res_count + 2'd1;
                            halted_next = 1'b1;
                        end
                        else
                        begin
                            res[res_count[0]] = mk(1'b1, KIND_BOOL, 8'h00, ERR_NONE, line_next);
                            res_count = res_count + 2'd1;
                            rescan    = 1'b1;
                        end
                    end
                    default:
                    begin
                        rescan = 1'b1;
                    end
                endcase

                // scan the byte from idle
                if (rescan)
                begin
                    mode_next  = MODE_IDLE;
                    len_next   = '0;
                    match_next = 3'b111;
                    if (!is_space(data_byte))
                    begin
                        priority case (data_byte)
                            CH_BRACE_OPN:
                            begin
                                res[res_count[0]] = mk(1'b1, KIND_BRACE_OPEN, 8'h00,
                                                       ERR_NONE, line_next);
                                res_count = res_count + 2'd1;
                            end
                            CH_BRACE_CLS:
                            begin
                                res[res_count[0]] = mk(1'b1, KIND_BRACE_CLOSE, 8'h00,
                                                       ERR_NONE, line_next);
                                res_count = res_count + 2'd1;
                            end
                            CH_BRACKET_OPN:
                            begin
                                res[res_count[0]] = mk(1'b1, KIND_BRACKET_OPEN, 8'h00,
                                                       ERR_NONE, line_next);
                                res_count = res_count + 2'd1;
                            end
                            CH_BRACKET_CLS:
                            begin
                                res[res_count[0]] = mk(1'b1, KIND_BRACKET_CLOSE, 8'h00,
                                                       ERR_NONE, line_next);
                                res_count = res_count + 2'd1;
                            end
                            CH_COLON:
                            begin
                                res[res_count[0]] = mk(1'b1, KIND_COLON, 8'h00,
                                                       ERR_NONE, line_next);
                                res_count = res_count + 2'd1;
                            end
                            CH_COMMA:
                            begin
                                res[res_count[0]] = mk(1'b1, KIND_COMMA, 8'h00,
                                                       ERR_NONE, line_next);
                                res_count = res_count + 2'd1;
                            end
                            CH_QUOTE:
                            begin
                                mode_next = MODE_STR;
                            end
                            default:
                            begin
                                if (is_digit(data_byte))
                                begin
                                    mode_next = MODE_INT;
                                    add_byte  = 1'b1;
                                end
                                else if (data_byte == CH_DOT)
                                begin
                                    mode_next = MODE_FRAC;
                                    add_byte  = 1'b1;
                                end
                                else if (is_alpha(data_byte))
                                begin
                                    mode_next = MODE_WORD;
                                    add_byte  = 1'b1;
                                end
                                else
                                begin
                                    res[res_count[0]] = mk(1'b0, KIND_BRACE_OPEN, data_byte,
                                                           ERR_UNEXPECTED, line_next);
                                    res_count   = res_count + 2'd1;
                                    halted_next = 1'b1;
                                end
                            end
                        endcase
                    end
                end

                // append the byte to the lexeme
                if (add_byte)
                begin
                    if (len_next >= LEN_W'(MAX_LEXEME))
                    begin
                        res[res_count[0]] = mk(1'b0, KIND_BRACE_OPEN, 8'h00,
                                               ERR_TOO_LONG, line_next);
                        halted_next = 1'b1;
                    end
                    else
                    begin
                        if (mode_next == MODE_WORD)
                        begin
                            for (int i = 0; i < 3; i++)
                            begin
                                if (len_next >= LEN_W'(word_len(2'(i))) ||
                                    word_char(2'(i), len_next[2:0]) != data_byte)
                                begin
                                    match_next[i] = 1'b0;
                                end
                            end
                        end
                        len_next = LEN_W'(len_next + 1'b1);
                        res[res_count[0]] = mk(1'b0, KIND_BRACE_OPEN, data_byte,
                                               ERR_NONE, line_next);
                    end
                    res_count = res_count + 2'd1;
                end
            end
        end

        // mark the last result of this byte
        if (res_count == 2'd1)
        begin
            res[0].last_of_run = 1'b1;
        end
        else if (res_count == 2'd2)
        begin
            res[1].last_of_run = 1'b1;
        end
    end

    assign push_first        = res[0];
    assign push_second       = res[1];
    assign status.halted     = halted_reg;
    assign status.push_count = step_en ? res_count : 2'd0;

    // scanner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            match_reg  <= 3'b111;
            len_reg    <= '0;
            line_reg   <= 16'd1;
            halted_reg <= 1'b0;
        end
        else
        begin
            if (step_en)
            begin
                mode_reg   <= mode_next;
                match_reg  <= match_next;
                len_reg    <= len_next;
                halted_reg <= halted_next;
            end
            if (cfg_we)
            begin
                line_reg <= cfg_data;
            end
            else if (step_en)
            begin
                line_reg <= line_next;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/jts_out_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none

module jts_out_fifo
    import jts_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic [1:0]   push_count,
    input  wire result_t      push_first,
    input  wire result_t      push_second,
    output logic              out_valid,
    input  wire logic         out_ready,
    output result_t           head,
    output fifo_status_t      status
);

    result_t            mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic               pop;

    assign out_valid    = (level_reg != '0);
    assign pop          = out_valid && out_ready;
    assign head         = mem[rd_ptr_reg];
    assign status.level = level_reg;
    assign level_next   = LEVEL_W'(level_reg + LEVEL_W'(push_count) - LEVEL_W'(pop));

    // result storage, up to two writes per cycle
    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push_first;
        end
        if (push_count == 2'd2)
        begin
            mem[FIFO_AW'(wr_ptr_reg + FIFO_AW'(1))] <= push_second;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= FIFO_AW'(wr_ptr_reg + FIFO_AW'(push_count));
            if (pop)
            begin
                rd_ptr_reg <= FIFO_AW'(rd_ptr_reg + FIFO_AW'(1));
            end
            level_reg <= level_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/json_token_scanner_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Streaming JSON lexer: takes one text byte (or an end-of-input mark) per transfer and
// produces zero, one or two result transfers per byte, in order, each tagged with the
// line number and a last-of-run flag. The scanner updates its state in the cycle a byte
// is taken and writes its results into a four-entry result queue, from whose head they
// appear on the output. A byte is taken whenever the queue has room for two results, so
// bytes flow at one per cycle while each gives at most one result and the output is ready;
// bytes giving two results are limited by the single-result-per-cycle output, which then
// sets the sustained byte rate. The start_line write loads the line counter directly.
// After any error the scanner takes and drops every byte until reset.
module json_token_scanner_core
    import jts_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        end_of_input,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             token_done,
    output logic [3:0]       token_kind,
    output logic [7:0]       lexeme_byte,
    output logic [2:0]       error_code,
    output logic [15:0]      line_number,
    output logic             last_of_run
);

    result_t      push_first;
    result_t      push_second;
    result_t      head;
    scan_status_t scan_status;
    fifo_status_t fifo_status;
    logic         in_fire;
    logic         cfg_fire;

    // handshakes: input waits for room for two results
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_ready  = (fifo_status.level <= LEVEL_W'(FIFO_DEPTH - 2));
    assign in_fire   = in_valid && in_ready;

    jts_scan u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_en      (in_fire),
        .data_byte    (data_byte),
        .end_of_input (end_of_input),
        .cfg_we       (cfg_fire),
        .cfg_data     (cfg_data),
        .push_first   (push_first),
        .push_second  (push_second),
        .status       (scan_status)
    );

    jts_out_fifo u_out_fifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_count  (scan_status.push_count),
        .push_first  (push_first),
        .push_second (push_second),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .head        (head),
        .status      (fifo_status)
    );

    // result fields
    assign token_done  = head.token_done;
    assign token_kind  = head.token_kind;
    assign lexeme_byte = head.lexeme_byte;
    assign error_code  = head.error_code;
    assign line_number = head.line_number;
    assign last_of_run = head.last_of_run;

    // queue never overfills
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_status.level <= LEVEL_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    // a pair of results is marked last only on the second
    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        scan_status.push_count == 2'd2 |->
            (!push_first.last_of_run && push_second.last_of_run))
        else $error("last_of_run misplaced on a result pair");

    // an error result halts the scanner
    a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
        ((scan_status.push_count == 2'd1 && push_first.error_code != ERR_NONE) ||
         (scan_status.push_count == 2'd2 && push_second.error_code != ERR_NONE))
        |=> scan_status.halted)
        else $error("error result without halt");

    // a halted scanner produces nothing
    a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        scan_status.halted |-> scan_status.push_count == 2'd0)
        else $error("result produced while halted");

endmodule

`default_nettype wire
